/* src/lbmc_pkg.sv */
// shared types, constants and saturating fixed-point arithmetic for the d2q9 collision node
package lbmc_pkg;

	localparam int W = 32;
	localparam int F = W - 4;
	localparam int NDIR = 9;
	localparam int QDEPTH = 4;
	localparam int DIV_LAT = W + 1;

	typedef logic signed [W-1:0] val_t;
	typedef logic [W-2:0] omega_t;

	localparam omega_t OMEGA_RESET = omega_t'(525407376);

	localparam val_t MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam val_t MIN_V = {1'b1, {(W-1){1'b0}}};

	localparam longint ONE_L = longint'(1) << F;
	localparam val_t ONE = val_t'(ONE_L);
	localparam val_t HALF = val_t'(ONE_L / 2);
	localparam val_t THREE_HALVES = val_t'(ONE_L + ONE_L / 2);
	localparam val_t WEIGHT [3] = '{val_t'(ONE_L / 36), val_t'(ONE_L / 9),
		val_t'((4 * ONE_L) / 9)};

	localparam int DIR_X [NDIR] = '{1, 1, 1, 0, 0, 0, -1, -1, -1};
	localparam int DIR_Y [NDIR] = '{1, 0, -1, 1, 0, -1, 1, 0, -1};
	localparam int WSEL [NDIR] = '{0, 1, 0, 1, 2, 1, 0, 1, 0};

	// item held between front and back
	typedef struct packed {
		val_t [NDIR-1:0] fin;
		val_t rho;
		val_t mx;
		val_t my;
		val_t isum;
		val_t s3;
		val_t den;
		val_t iux;
		logic solid;
		logic inlet;
	} node_t;

	// item carried down the back pipeline
	typedef struct packed {
		val_t [NDIR-1:0] fin;
		val_t [NDIR-1:0] cu;
		val_t [NDIR-1:0] tmp;
		val_t [NDIR-1:0] feq;
		val_t [2:0] rw;
		val_t rho;
		val_t mx;
		val_t my;
		val_t isum;
		val_t iux;
		val_t ux;
		val_t uy;
		val_t uxx;
		val_t uyy;
		val_t usqr;
		logic solid;
		logic inlet;
	} work_t;

	function automatic val_t sadd(val_t a, val_t b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) sadd = s[W] ? MIN_V : MAX_V;
		else sadd = val_t'(s[W-1:0]);
	endfunction

	function automatic val_t ssub(val_t a, val_t b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) ssub = s[W] ? MIN_V : MAX_V;
		else ssub = val_t'(s[W-1:0]);
	endfunction

	// product truncated toward zero, saturated
	function automatic val_t smul(val_t a, val_t b);
		logic [W-1:0] ma;
		logic [W-1:0] mb;
		logic [2*W-1:0] p;
		logic [2*W-F-1:0] m;
		logic neg;
		ma = a[W-1] ? (~a + 1'b1) : a;
		mb = b[W-1] ? (~b + 1'b1) : b;
		p = ma * mb;
		m = p[2*W-1:F];
		neg = a[W-1] ^ b[W-1];
		if (m >= ((2*W-F)'(1) << (W-1))) begin
			smul = neg ? MIN_V : MAX_V;
		end else begin
			smul = val_t'(m[W-1:0]);
			if (neg) smul = -smul;
		end
	endfunction

endpackage

/* src/lbmc_if.sv */
// request channels of the collision node: node populations in, collided results out
interface lbmc_node_if import lbmc_pkg::*; ();
	logic valid;
	logic ready;
	val_t pop_in_0;
	val_t pop_in_1;
	val_t pop_in_2;
	val_t pop_in_3;
	val_t pop_in_4;
	val_t pop_in_5;
	val_t pop_in_6;
	val_t pop_in_7;
	val_t pop_in_8;
	logic is_solid;
	logic is_inlet;
	val_t inlet_ux;

	modport source (output valid, pop_in_0, pop_in_1, pop_in_2, pop_in_3, pop_in_4,
		pop_in_5, pop_in_6, pop_in_7, pop_in_8, is_solid, is_inlet, inlet_ux,
		input ready);
	modport sink (input valid, pop_in_0, pop_in_1, pop_in_2, pop_in_3, pop_in_4,
		pop_in_5, pop_in_6, pop_in_7, pop_in_8, is_solid, is_inlet, inlet_ux,
		output ready);
endinterface

interface lbmc_result_if import lbmc_pkg::*; ();
	logic valid;
	logic ready;
	val_t pop_out_0;
	val_t pop_out_1;
	val_t pop_out_2;
	val_t pop_out_3;
	val_t pop_out_4;
	val_t pop_out_5;
	val_t pop_out_6;
	val_t pop_out_7;
	val_t pop_out_8;
	val_t density;
	val_t velocity_x;
	val_t velocity_y;

	modport source (output valid, pop_out_0, pop_out_1, pop_out_2, pop_out_3, pop_out_4,
		pop_out_5, pop_out_6, pop_out_7, pop_out_8, density, velocity_x, velocity_y,
		input ready);
	modport sink (input valid, pop_out_0, pop_out_1, pop_out_2, pop_out_3, pop_out_4,
		pop_out_5, pop_out_6, pop_out_7, pop_out_8, density, velocity_x, velocity_y,
		output ready);
endinterface

/* src/lbmc_front.sv */
// front end: accepts node requests and forms the moment sums in two stages
module lbmc_front import lbmc_pkg::*; (
	input logic clk,
	input logic arst_n,
	lbmc_node_if.sink node,
	output logic push_valid,
	input logic push_ready,
	output node_t push_item
);

	node_t n_s1;
	node_t n_s2;
	logic v_s1;
	logic v_s2;
	logic adv;
	node_t c1;
	node_t c2;
	val_t p [NDIR];

	assign adv = !v_s2 || push_ready;
	assign node.ready = adv || !v_s1;
	assign push_valid = v_s2;
	assign push_item = n_s2;

	always_comb begin
		p[0] = node.pop_in_0;
		p[1] = node.pop_in_1;
		p[2] = node.pop_in_2;
		p[3] = node.pop_in_3;
		p[4] = node.pop_in_4;
		p[5] = node.pop_in_5;
		p[6] = node.pop_in_6;
		p[7] = node.pop_in_7;
		p[8] = node.pop_in_8;
		for (int f = 0; f < NDIR; f++) c1.fin[f] = p[f];
		// first half of the running sums, in population order
		c1.rho = sadd(sadd(sadd(sadd(p[0], p[1]), p[2]), p[3]), p[4]);
		c1.mx = sadd(sadd(p[0], p[1]), p[2]);
		c1.my = sadd(ssub(p[0], p[2]), p[3]);
		c1.isum = sadd(sadd(p[3], p[4]), p[5]);
		c1.s3 = sadd(sadd(p[6], p[7]), p[8]);
		c1.iux = node.inlet_ux;
		c1.den = ssub(ONE, node.inlet_ux);
		c1.solid = node.is_solid;
		c1.inlet = node.is_inlet;
	end

	always_comb begin
		c2 = n_s1;
		c2.rho = sadd(sadd(sadd(sadd(n_s1.rho, n_s1.fin[5]), n_s1.fin[6]), n_s1.fin[7]),
			n_s1.fin[8]);
		c2.mx = ssub(ssub(ssub(n_s1.mx, n_s1.fin[6]), n_s1.fin[7]), n_s1.fin[8]);
		c2.my = ssub(sadd(ssub(n_s1.my, n_s1.fin[5]), n_s1.fin[6]), n_s1.fin[8]);
		c2.isum = sadd(n_s1.isum, sadd(n_s1.s3, n_s1.s3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (node.ready) v_s1 <= node.valid;
			if (adv) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (node.ready) n_s1 <= c1;
		if (adv) n_s2 <= c2;
	end

endmodule

/* src/lbmc_queue.sv */
// short register queue between front and back
module lbmc_queue import lbmc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input node_t push_item,
	output logic pop_valid,
	input logic pop_ready,
	output node_t pop_item
);

	localparam int PW = $clog2(QDEPTH);

	node_t mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = cnt_q != (PW+1)'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_item = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

/* src/lbmc_div.sv */
// pipelined reciprocal: one over a signed value, one quotient bit per stage
module lbmc_div import lbmc_pkg::*; (
	input logic clk,
	input logic en,
	input val_t den,
	output val_t quo
);

	localparam int NSTEP = W - 1;
	localparam logic [W-1:0] SAT_LIM = W'(1) << (W - 7);

	logic [W-1:0] md_s [NSTEP+1];
	logic [W-1:0] r_s [NSTEP+1];
	logic [W-2:0] q_s [NSTEP+1];
	logic neg_s [NSTEP+1];
	logic sat_s [NSTEP+1];
	logic [W:0] nxt [1:NSTEP];
	val_t quo_s;
	logic [W-1:0] mag;
	val_t qv;

	function automatic logic [W:0] div_step(logic [W-1:0] r, logic [W-1:0] md);
		logic [W:0] rr;
		logic [W:0] sub;
		rr = {r, 1'b0};
		sub = rr - {1'b0, md};
		if (rr >= {1'b0, md}) div_step = {sub[W-1:0], 1'b1};
		else div_step = {rr[W-1:0], 1'b0};
	endfunction

	assign mag = den[W-1] ? (~den + 1'b1) : den;
	assign qv = val_t'({1'b0, q_s[NSTEP]});
	assign quo = quo_s;

	// partial remainder and quotient bit of every stage
	always_comb begin
		for (int k = 1; k <= NSTEP; k++) nxt[k] = div_step(r_s[k-1], md_s[k-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// quotients of at least the top of range only occur at or below this divisor
			md_s[0] <= mag;
			neg_s[0] <= den[W-1];
			sat_s[0] <= mag <= SAT_LIM;
			r_s[0] <= SAT_LIM;
			q_s[0] <= '0;
			for (int k = 1; k <= NSTEP; k++) begin
				r_s[k] <= nxt[k][W:1];
				q_s[k] <= {q_s[k-1][W-3:0], nxt[k][0]};
				md_s[k] <= md_s[k-1];
				neg_s[k] <= neg_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
			if (sat_s[NSTEP]) quo_s <= neg_s[NSTEP] ? MIN_V : MAX_V;
			else quo_s <= neg_s[NSTEP] ? -qv : qv;
		end
	end

endmodule

/* src/lbmc_back.sv */
// back end: reciprocal, velocity, equilibrium, inlet rebuild, relax or bounce-back
module lbmc_back import lbmc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input node_t pop_item,
	input omega_t omega,
	lbmc_result_if.source result
);

	localparam int NV = DIV_LAT + 10;

	logic [NV-1:0] vld_q;
	logic adv;
	node_t n_s0;
	work_t line_s [DIV_LAT];
	work_t w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7, w_s8, w_s9;
	work_t l0, w1, w2, w3, w4, w5, w6, w7, w8, w9;
	val_t inv_a;
	val_t inv_b;
	val_t om;

	assign adv = !vld_q[NV-1] || result.ready;
	assign pop_ready = adv;
	assign om = val_t'({1'b0, omega});

	lbmc_div u_div_rho (.clk(clk), .en(adv), .den(n_s0.rho), .quo(inv_a));
	lbmc_div u_div_inl (.clk(clk), .en(adv), .den(n_s0.den), .quo(inv_b));

	always_comb begin
		l0 = '0;
		l0.fin = n_s0.fin;
		l0.rho = n_s0.rho;
		l0.mx = n_s0.mx;
		l0.my = n_s0.my;
		l0.isum = n_s0.isum;
		l0.iux = n_s0.iux;
		l0.solid = n_s0.solid;
		l0.inlet = n_s0.inlet;
	end

	always_comb begin
		w1 = line_s[DIV_LAT-1];
		if (w1.inlet) begin
			w1.ux = w1.iux;
			w1.uy = '0;
			w1.rho = smul(inv_b, w1.isum);
		end else begin
			w1.ux = smul(w1.mx, inv_a);
			w1.uy = smul(w1.my, inv_a);
		end
	end

	always_comb begin
		val_t d;
		w2 = w_s1;
		w2.uxx = smul(w_s1.ux, w_s1.ux);
		w2.uyy = smul(w_s1.uy, w_s1.uy);
		for (int k = 0; k < 3; k++) w2.rw[k] = smul(w_s1.rho, WEIGHT[k]);
		for (int f = 0; f < NDIR; f++) begin
			d = '0;
			if (DIR_X[f] > 0) d = sadd(d, w_s1.ux);
			else if (DIR_X[f] < 0) d = ssub(d, w_s1.ux);
			if (DIR_Y[f] > 0) d = sadd(d, w_s1.uy);
			else if (DIR_Y[f] < 0) d = ssub(d, w_s1.uy);
			w2.cu[f] = sadd(sadd(d, d), d);
		end
	end

	always_comb begin
		w3 = w_s2;
		w3.usqr = sadd(w_s2.uxx, w_s2.uyy);
		for (int f = 0; f < NDIR; f++) w3.tmp[f] = smul(w_s2.cu[f], w_s2.cu[f]);
	end

	always_comb begin
		w4 = w_s3;
		w4.usqr = smul(THREE_HALVES, w_s3.usqr);
		for (int f = 0; f < NDIR; f++) w4.tmp[f] = smul(w_s3.tmp[f], HALF);
	end

	always_comb begin
		w5 = w_s4;
		for (int f = 0; f < NDIR; f++)
			w5.tmp[f] = ssub(sadd(sadd(ONE, w_s4.cu[f]), w_s4.tmp[f]), w_s4.usqr);
	end

	always_comb begin
		w6 = w_s5;
		for (int f = 0; f < NDIR; f++) w6.feq[f] = smul(w_s5.rw[WSEL[f]], w_s5.tmp[f]);
	end

	always_comb begin
		w7 = w_s6;
		// inlet rebuild of the three unknown populations
		if (w_s6.inlet) begin
			for (int f = 0; f < 3; f++)
				w7.fin[f] = ssub(sadd(w_s6.feq[f], w_s6.fin[8-f]), w_s6.feq[8-f]);
		end
		for (int f = 0; f < NDIR; f++) w7.tmp[f] = ssub(w7.fin[f], w_s6.feq[f]);
	end

	always_comb begin
		w8 = w_s7;
		for (int f = 0; f < NDIR; f++) w8.tmp[f] = smul(om, w_s7.tmp[f]);
	end

	always_comb begin
		w9 = w_s8;
		for (int f = 0; f < NDIR; f++) begin
			if (w_s8.solid) w9.tmp[f] = w_s8.fin[8-f];
			else w9.tmp[f] = ssub(w_s8.fin[f], w_s8.tmp[f]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NV-2:0], pop_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s0 <= pop_item;
			line_s[0] <= l0;
			for (int k = 1; k < DIV_LAT; k++) line_s[k] <= line_s[k-1];
			w_s1 <= w1;
			w_s2 <= w2;
			w_s3 <= w3;
			w_s4 <= w4;
			w_s5 <= w5;
			w_s6 <= w6;
			w_s7 <= w7;
			w_s8 <= w8;
			w_s9 <= w9;
		end
	end

	assign result.valid = vld_q[NV-1];
	assign result.pop_out_0 = w_s9.tmp[0];
	assign result.pop_out_1 = w_s9.tmp[1];
	assign result.pop_out_2 = w_s9.tmp[2];
	assign result.pop_out_3 = w_s9.tmp[3];
	assign result.pop_out_4 = w_s9.tmp[4];
	assign result.pop_out_5 = w_s9.tmp[5];
	assign result.pop_out_6 = w_s9.tmp[6];
	assign result.pop_out_7 = w_s9.tmp[7];
	assign result.pop_out_8 = w_s9.tmp[8];
	assign result.density = w_s9.rho;
	assign result.velocity_x = w_s9.ux;
	assign result.velocity_y = w_s9.uy;

endmodule

/* src/lbm_d2q9_node_collision.sv */
// top level of the d2q9 bgk collision node
// usage
//  node: one request per lattice node, nine populations, solid and inlet flags
//   and the inlet x velocity, all signed q4.28
//  result: one request per node, nine collided populations plus the density
//   and velocity that fed the equilibrium, in the order the nodes came in
//  cfg_we / cfg_wdata: writes omega (unsigned q.28), only while the block is empty
// throughput: one node per cycle, sustained, while result is not stalled
// pipeline: the bulk of the path from node accept to result accept is
//  the two reciprocal units, which retire one quotient bit per stage
// structure: a two stage front forms the moment sums, a four entry queue
//  decouples it from the back pipeline, which runs reciprocal, velocity,
//  equilibrium, inlet rebuild and relaxation or bounce-back
// stall: when result is not taken the whole back pipeline freezes, the queue
//  fills, then the front holds and drops node.ready
// reset: all valid flags clear at once, omega returns to about 1.957
module lbm_d2q9_node_collision import lbmc_pkg::*; (
	input logic clk,
	input logic arst_n,
	lbmc_node_if.sink node,
	lbmc_result_if.source result,
	input logic cfg_we,
	input omega_t cfg_wdata
);

	// relaxation rate register
	omega_t omega_q;

	// front to queue
	logic f_valid;
	logic f_ready;
	node_t f_item;

	// queue to back
	logic b_valid;
	logic b_ready;
	node_t b_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omega_q <= OMEGA_RESET;
		end else if (cfg_we) begin
			omega_q <= cfg_wdata;
		end
	end

	lbmc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.node(node),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_item(f_item)
	);

	lbmc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_item(f_item),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_item(b_item)
	);

	lbmc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_item(b_item),
		.omega(omega_q),
		.result(result)
	);

endmodule

/* tb/sv/tb_top.sv */
// testbench for the d2q9 bgk collision node: directed table then random nodes, self-checking
`timescale 1ns / 1ps

module tb_top;
	import lbmc_pkg::*;

	// one lattice node as offered on the node channel
	typedef struct {
		val_t pop [NDIR];
		logic solid;
		logic inlet;
		val_t iux;
	} node_req_t;

	// one collided result as taken from the result channel
	typedef struct {
		val_t pop [NDIR];
		val_t rho;
		val_t ux;
		val_t uy;
	} collided_t;

	// a row of the directed table; typed rows carry a hand-worked result
	typedef struct {
		node_req_t req;
		bit typed;
		collided_t want;
	} node_row_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLDOFF_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic cfg_we;
	omega_t cfg_wdata;

	lbmc_node_if node_ch ();
	lbmc_result_if res_ch ();

	lbm_d2q9_node_collision dut (
		.clk(clk),
		.arst_n(arst_n),
		.node(node_ch),
		.result(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of the omega register
	omega_t omega_shadow;

	node_row_t offered_q [$];     // driven on the node channel, not yet accepted
	collided_t collided_q [$];    // predicted results awaiting the result channel

	int mismatches = 0;
	int nodes_accepted = 0;
	int results_checked = 0;
	int quiet_cycles = 0;
	int tx_idle_pct;
	int rx_idle_pct;
	bit holdoff_req = 1'b0;
	bit holdoff_done = 1'b0;
	int holdoff_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// saturating q4.28 arithmetic, written out at full width
	// ---------------------------------------------------------------
	function automatic val_t clamp_q(longint v);
		if (v > longint'(MAX_V)) return MAX_V;
		if (v < longint'(MIN_V)) return MIN_V;
		return val_t'(v);
	endfunction

	function automatic val_t q_add(val_t a, val_t b);
		return clamp_q(longint'(a) + longint'(b));
	endfunction

	function automatic val_t q_sub(val_t a, val_t b);
		return clamp_q(longint'(a) - longint'(b));
	endfunction

	// magnitude with sign applied, saturating at either end
	function automatic val_t signed_mag(logic [63:0] m, bit neg);
		if (!neg) return (m > 64'(MAX_V)) ? MAX_V : val_t'(m);
		if (m >= 64'h8000_0000) return MIN_V;
		return val_t'(-longint'(m));
	endfunction

	function automatic logic [63:0] mag_of(val_t v);
		longint l;
		l = longint'(v);
		return (l < 0) ? 64'(-l) : 64'(l);
	endfunction

	// product truncated toward zero
	function automatic val_t q_mul(val_t a, val_t b);
		logic [63:0] p;
		p = mag_of(a) * mag_of(b);
		return signed_mag(p >> F, a[W-1] ^ b[W-1]);
	endfunction

	// quotient truncated toward zero, division by zero saturates unless the numerator is zero
	function automatic val_t q_div(val_t n, val_t d);
		logic [63:0] q;
		if (d == 0) begin
			if (n == 0) return '0;
			return (n > 0) ? MAX_V : MIN_V;
		end
		q = (mag_of(n) << F) / mag_of(d);
		return signed_mag(q, n[W-1] ^ d[W-1]);
	endfunction

	// ---------------------------------------------------------------
	// collision of one node: moments, velocity, equilibrium, inlet
	// rebuild, then relaxation or bounce-back
	// ---------------------------------------------------------------
	function automatic collided_t collide_node(node_req_t r, omega_t om);
		collided_t res;
		val_t fin [NDIR];
		val_t feq [NDIR];
		val_t rho, mx, my, inv, ux, uy, usqr, s2, s3, d, cu, t, omv;
		rho = '0;
		mx = '0;
		my = '0;
		omv = val_t'({1'b0, om});
		for (int f = 0; f < NDIR; f++) begin
			fin[f] = r.pop[f];
			rho = q_add(rho, fin[f]);
			if (DIR_X[f] > 0) mx = q_add(mx, fin[f]);
			if (DIR_X[f] < 0) mx = q_sub(mx, fin[f]);
			if (DIR_Y[f] > 0) my = q_add(my, fin[f]);
			if (DIR_Y[f] < 0) my = q_sub(my, fin[f]);
		end
		inv = q_div(ONE, rho);
		ux = q_mul(mx, inv);
		uy = q_mul(my, inv);
		// velocity inflow: forced velocity, density from the known populations
		if (r.inlet) begin
			s2 = q_add(q_add(fin[3], fin[4]), fin[5]);
			s3 = q_add(q_add(fin[6], fin[7]), fin[8]);
			ux = r.iux;
			uy = '0;
			rho = q_mul(q_div(ONE, q_sub(ONE, ux)), q_add(s2, q_add(s3, s3)));
		end
		usqr = q_mul(THREE_HALVES, q_add(q_mul(ux, ux), q_mul(uy, uy)));
		for (int f = 0; f < NDIR; f++) begin
			d = '0;
			if (DIR_X[f] > 0) d = q_add(d, ux);
			if (DIR_X[f] < 0) d = q_sub(d, ux);
			if (DIR_Y[f] > 0) d = q_add(d, uy);
			if (DIR_Y[f] < 0) d = q_sub(d, uy);
			cu = q_add(q_add(d, d), d);
			t = q_sub(q_add(q_add(ONE, cu), q_mul(q_mul(cu, cu), HALF)), usqr);
			feq[f] = q_mul(q_mul(rho, WEIGHT[WSEL[f]]), t);
		end
		// unknown populations rebuilt from their opposites
		if (r.inlet) begin
			for (int f = 0; f < 3; f++)
				fin[f] = q_sub(q_add(feq[f], fin[NDIR-1-f]), feq[NDIR-1-f]);
		end
		for (int f = 0; f < NDIR; f++) begin
			if (r.solid) res.pop[f] = fin[NDIR-1-f];
			else res.pop[f] = q_sub(fin[f], q_mul(omv, q_sub(fin[f], feq[f])));
		end
		res.rho = rho;
		res.ux = ux;
		res.uy = uy;
		return res;
	endfunction

	task automatic report_mismatch(string what, val_t got, val_t want);
		$display("mismatch on result %0d, %s: got %h expected %h",
			results_checked, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// node monitor: each accepted request gets its expected result
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		node_row_t row;
		if (arst_n && node_ch.valid && node_ch.ready) begin
			row = offered_q.pop_front();
			if (row.typed) collided_q.push_back(row.want);
			else collided_q.push_back(collide_node(row.req, omega_shadow));
			nodes_accepted++;
		end
	end

	// result monitor: compare field by field with the oldest expectation
	always @(posedge clk) begin
		collided_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.pop[0] = res_ch.pop_out_0;
			got.pop[1] = res_ch.pop_out_1;
			got.pop[2] = res_ch.pop_out_2;
			got.pop[3] = res_ch.pop_out_3;
			got.pop[4] = res_ch.pop_out_4;
			got.pop[5] = res_ch.pop_out_5;
			got.pop[6] = res_ch.pop_out_6;
			got.pop[7] = res_ch.pop_out_7;
			got.pop[8] = res_ch.pop_out_8;
			got.rho = res_ch.density;
			got.ux = res_ch.velocity_x;
			got.uy = res_ch.velocity_y;
			if (collided_q.size() == 0) begin
				report_mismatch("unexpected result, density", got.rho, '0);
			end else begin
				want = collided_q.pop_front();
				for (int f = 0; f < NDIR; f++)
					if (got.pop[f] !== want.pop[f])
						report_mismatch($sformatf("pop_out_%0d", f), got.pop[f], want.pop[f]);
				if (got.rho !== want.rho) report_mismatch("density", got.rho, want.rho);
				if (got.ux !== want.ux) report_mismatch("velocity_x", got.ux, want.ux);
				if (got.uy !== want.uy) report_mismatch("velocity_y", got.uy, want.uy);
			end
			results_checked++;
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	always @(posedge clk) begin
		if (holdoff_req && !holdoff_done) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_done <= 1'b1;
			res_ch.ready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog: too long without any request moving on either side
	always @(posedge clk) begin
		if ((node_ch.valid && node_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", collided_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	function automatic val_t small_q(int span);
		return val_t'($urandom_range(2 * span) - span);
	endfunction

	function automatic val_t edge_q();
		case ($urandom_range(5))
			0: return MAX_V;
			1: return MIN_V;
			2: return ONE;
			3: return -ONE;
			4: return '0;
			default: return val_t'($urandom);
		endcase
	endfunction

	function automatic node_req_t uniform_node(val_t p, bit s, bit i, val_t u);
		node_req_t r;
		foreach (r.pop[f]) r.pop[f] = p;
		r.solid = s;
		r.inlet = i;
		r.iux = u;
		return r;
	endfunction

	// node near equilibrium at rest, density about one
	function automatic node_req_t rest_node(bit s, bit i, val_t u);
		node_req_t r;
		r = uniform_node('0, s, i, u);
		foreach (r.pop[f]) r.pop[f] = WEIGHT[WSEL[f]];
		return r;
	endfunction

	// mostly physical nodes with random content, some noise and edge values
	function automatic node_req_t random_node();
		node_req_t r;
		int kind;
		kind = $urandom_range(99);
		if (kind < 70) begin
			r = rest_node($urandom_range(9) == 0, $urandom_range(99) < 15,
				small_q(int'(ONE_L / 5)));
			foreach (r.pop[f]) r.pop[f] = q_add(r.pop[f], small_q(int'(ONE_L / 64)));
		end else if (kind < 90) begin
			r = uniform_node('0, $urandom_range(1), $urandom_range(1), val_t'($urandom));
			foreach (r.pop[f]) r.pop[f] = val_t'($urandom);
		end else begin
			r = uniform_node('0, $urandom_range(1), $urandom_range(1), edge_q());
			foreach (r.pop[f]) r.pop[f] = edge_q();
		end
		return r;
	endfunction

	// offer one node, with random idle cycles ahead of it
	task automatic send_node(node_row_t row);
		while ($urandom_range(99) < tx_idle_pct) begin
			node_ch.valid <= 1'b0;
			@(posedge clk);
		end
		offered_q.push_back(row);
		node_ch.pop_in_0 <= row.req.pop[0];
		node_ch.pop_in_1 <= row.req.pop[1];
		node_ch.pop_in_2 <= row.req.pop[2];
		node_ch.pop_in_3 <= row.req.pop[3];
		node_ch.pop_in_4 <= row.req.pop[4];
		node_ch.pop_in_5 <= row.req.pop[5];
		node_ch.pop_in_6 <= row.req.pop[6];
		node_ch.pop_in_7 <= row.req.pop[7];
		node_ch.pop_in_8 <= row.req.pop[8];
		node_ch.is_solid <= row.req.solid;
		node_ch.is_inlet <= row.req.inlet;
		node_ch.inlet_ux <= row.req.iux;
		node_ch.valid <= 1'b1;
		do @(posedge clk); while (!(node_ch.valid && node_ch.ready));
	endtask

	task automatic send_random(int count);
		node_row_t row;
		row.typed = 1'b0;
		repeat (count) begin
			row.req = random_node();
			send_node(row);
		end
	endtask

	// sender pauses until every outstanding result is back, then lets the pipe settle
	task automatic drain_results();
		node_ch.valid <= 1'b0;
		@(posedge clk);
		while (collided_q.size() != 0 || offered_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_omega(omega_t v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		omega_shadow = v;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		node_row_t rows [$];
		node_row_t row;
		val_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		node_ch.valid = 1'b0;
		node_ch.pop_in_0 = '0;
		node_ch.pop_in_1 = '0;
		node_ch.pop_in_2 = '0;
		node_ch.pop_in_3 = '0;
		node_ch.pop_in_4 = '0;
		node_ch.pop_in_5 = '0;
		node_ch.pop_in_6 = '0;
		node_ch.pop_in_7 = '0;
		node_ch.pop_in_8 = '0;
		node_ch.is_solid = 1'b0;
		node_ch.is_inlet = 1'b0;
		node_ch.inlet_ux = '0;
		omega_shadow = OMEGA_RESET;
		tx_idle_pct = 15;
		rx_idle_pct = 45;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset value of omega
		// empty node: zero density, reciprocal saturates, zero momentum keeps velocity zero
		row.req = uniform_node('0, 1'b0, 1'b0, '0);
		row.typed = 1'b1;
		foreach (row.want.pop[f]) row.want.pop[f] = '0;
		row.want.rho = '0;
		row.want.ux = '0;
		row.want.uy = '0;
		rows.push_back(row);
		// uniform solid node: bounce-back of equal populations, no momentum
		c = 32'sh0100_0000;
		row.req = uniform_node(c, 1'b1, 1'b0, '0);
		foreach (row.want.pop[f]) row.want.pop[f] = c;
		row.want.rho = 32'sh0900_0000;
		rows.push_back(row);
		row.typed = 1'b0;
		// saturation at both ends, fluid and solid, and a uniform negative node
		rows.push_back('{uniform_node(MAX_V, 1'b0, 1'b0, '0), 1'b0, row.want});
		rows.push_back('{uniform_node(MIN_V, 1'b0, 1'b0, '0), 1'b0, row.want});
		rows.push_back('{uniform_node(MAX_V, 1'b1, 1'b0, MAX_V), 1'b0, row.want});
		rows.push_back('{uniform_node(-c, 1'b0, 1'b0, '0), 1'b0, row.want});
		// rest equilibrium, fluid and solid
		rows.push_back('{rest_node(1'b0, 1'b0, '0), 1'b0, row.want});
		rows.push_back('{rest_node(1'b1, 1'b0, '0), 1'b0, row.want});
		// inlet: unit velocity makes the divisor zero, then extreme velocities, fluid and solid
		rows.push_back('{rest_node(1'b0, 1'b1, ONE), 1'b0, row.want});
		rows.push_back('{rest_node(1'b0, 1'b1, MIN_V), 1'b0, row.want});
		rows.push_back('{rest_node(1'b1, 1'b1, MAX_V), 1'b0, row.want});
		// inlet with solid: rebuild, then swap; then fluid inlet nodes
		rows.push_back('{rest_node(1'b1, 1'b1, val_t'(ONE_L / 10)), 1'b0, row.want});
		rows.push_back('{rest_node(1'b0, 1'b1, val_t'(ONE_L / 20)), 1'b0, row.want});
		rows.push_back('{rest_node(1'b0, 1'b1, '0), 1'b0, row.want});
		// zero density with momentum: velocity saturates; the second row adds extreme populations
		row.req = uniform_node('0, 1'b0, 1'b0, '0);
		row.req.pop[1] = ONE;
		row.req.pop[7] = -ONE;
		rows.push_back(row);
		row.req.pop[3] = MAX_V;
		row.req.pop[5] = MIN_V;
		rows.push_back(row);
		// fields at their extremes, mixed
		row.req = uniform_node(MAX_V, 1'b1, 1'b1, MIN_V);
		row.req.pop[0] = MIN_V;
		row.req.pop[4] = '0;
		rows.push_back(row);
		row.req = uniform_node(MIN_V, 1'b0, 1'b1, MAX_V);
		row.req.pop[8] = MAX_V;
		rows.push_back(row);
		foreach (rows[k]) send_node(rows[k]);
		drain_results();

		// largest omega
		write_omega('1);
		send_random(250);
		drain_results();

		// no relaxation at all, idling swapped
		write_omega('0);
		tx_idle_pct = 45;
		rx_idle_pct = 15;
		send_random(250);
		drain_results();

		// omega of one, full rate; result side holds off while nodes keep coming
		write_omega(omega_t'(ONE_L));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(20);
		holdoff_req = 1'b1;
		send_random(280);
		drain_results();

		$display("covered %0d nodes, %0d results checked, %0d mismatches",
			nodes_accepted, results_checked, mismatches);
		$display("omega at reset, zero, one and full scale; inlet, solid and saturation cases");
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
